// File: hw/rtl/iabst_pkg.sv
// shared constants, codes and types of the implicit array search tree
`timescale 1ns / 1ps

package iabst_pkg;

   localparam int TREE_LEVELS_DEF = 10;
   localparam int KEY_W           = 32;
   localparam int STATUS_W        = 3;
   localparam int HEIGHT_W        = 4;
   localparam int HEIGHT_MAX      = 15;
   // wide enough for any level count up to sixteen
   localparam int LEVEL_EXT_W     = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_NO_ROOM   = 3'd2,
      STATUS_FOUND     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_SEARCH = 1'b1
   } action_type;

   typedef struct packed {
      logic                    occupied;
      logic signed [KEY_W-1:0] key;
   } slot_word_type;

endpackage

// File: hw/rtl/iabst_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface iabst_req_if import iabst_pkg::*; ();
   logic                    valid;
   logic                    ready;
   action_type              action;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface iabst_rsp_if import iabst_pkg::*; ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [HEIGHT_W-1:0] tree_height;

   modport source (output valid, output status, output tree_height, input ready);
   modport sink   (input valid, input status, input tree_height, output ready);
endinterface

// File: hw/rtl/iabst_slot_ram.sv
// slot store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module iabst_slot_ram import iabst_pkg::*; #(
   parameter int AddrW = TREE_LEVELS_DEF
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  slot_word_type    wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output slot_word_type    rd_data
);

   slot_word_type mem [2**AddrW];
   slot_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/implicit_array_bst_top.sv
// top level of the implicit array binary search tree
`timescale 1ns / 1ps

//  channel   dir  handshake        payload
//  req_bus   in   valid / ready    action (1), key (32, signed)
//  rsp_bus   out  valid / ready    status (3), tree_height (4)
//
//  an item is taken only in the idle state, then walks the tree level by level;
//  the walk is paced by the slot ram read port
//  reset runs a clearing pass over every slot of the slot ram, one slot at a
//  time, and no request beat is taken during it
//  the result sits in an output register; a stalled response only holds the
//  block once a further result is ready behind it

module implicit_array_bst_top import iabst_pkg::*; #(
   parameter int TreeLevels = TREE_LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   iabst_req_if.sink   req_bus,
   iabst_rsp_if.source rsp_bus
);

   localparam int LvlW = $clog2(TreeLevels + 1);

   // one-hot control states
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [TreeLevels-1:0]    clr_ff, clr_in;
   logic [TreeLevels-1:0]    slot_ff, slot_in;
   logic [LvlW-1:0]          level_ff, level_in;
   logic [LvlW-1:0]          height_ff, height_in;
   action_type               action_ff, action_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   status_type               pend_status_ff, pend_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [HEIGHT_W-1:0]      rsp_height_ff, rsp_height_in;

   // slot ram ports
   logic                     wr_en;
   logic [TreeLevels-1:0]    wr_addr;
   slot_word_type            wr_data;
   logic [TreeLevels-1:0]    rd_addr;
   slot_word_type            rd_word;

   // walk decisions
   logic                     accept;
   logic                     out_free;
   logic                     here_match;
   logic                     go_right;
   logic                     last_level;
   logic                     is_search;
   logic                     height_grow;
   logic [LEVEL_EXT_W-1:0]   height_ext;
   logic [HEIGHT_W-1:0]      height_sat;

   iabst_slot_ram #(
      .AddrW(TreeLevels)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign accept            = req_bus.valid && req_bus.ready;
   assign out_free          = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.tree_height = rsp_height_ff;

   // key in the slot just read against the walking key
   assign here_match = (rd_word.key == key_ff);
   assign go_right   = (key_ff > $signed(rd_word.key));
   assign last_level = (level_ff == LvlW'(TreeLevels));
   assign is_search  = (action_ff == ACTION_SEARCH);

   // an insert that claims a slot below the current bottom grows the tree
   assign height_grow = (state_ff == ST_WALK) && !rd_word.occupied && !is_search &&
                        (level_ff > height_ff);
   assign height_in   = height_grow ? level_ff : height_ff;

   // reported height saturates at the field limit
   assign height_ext = LEVEL_EXT_W'(height_in);
   assign height_sat = (height_ext > LEVEL_EXT_W'(HEIGHT_MAX)) ?
                       HEIGHT_W'(HEIGHT_MAX) : height_ext[HEIGHT_W-1:0];

   always_comb begin
      logic       done;
      status_type status_c;

      done           = 1'b0;
      status_c       = STATUS_NOT_FOUND;
      state_in       = state_ff;
      clr_in         = clr_ff;
      slot_in        = slot_ff;
      level_in       = level_ff;
      action_in      = action_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_height_in  = rsp_height_ff;
      wr_en          = 1'b0;
      wr_addr        = slot_ff;
      wr_data        = '{occupied: 1'b1, key: key_ff};
      // root read is issued on the accepting edge
      rd_addr        = TreeLevels'(1);

      // response beat leaves the output register
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // wipe occupied bits one slot a cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + TreeLevels'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               action_in = req_bus.action;
               key_in    = req_bus.key;
               slot_in   = TreeLevels'(1);
               level_in  = LvlW'(1);
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!rd_word.occupied) begin
               // empty slot ends the walk; an insert claims it
               done = 1'b1;
               if (is_search) begin
                  status_c = STATUS_NOT_FOUND;
               end else begin
                  status_c = STATUS_INSERTED;
                  wr_en    = 1'b1;
               end
            end else if (here_match) begin
               done     = 1'b1;
               status_c = is_search ? STATUS_FOUND : STATUS_DUPLICATE;
            end else if (last_level) begin
               // walk would leave the deepest level
               done     = 1'b1;
               status_c = is_search ? STATUS_NOT_FOUND : STATUS_NO_ROOM;
            end else begin
               slot_in  = {slot_ff[TreeLevels-2:0], go_right};
               level_in = level_ff + LvlW'(1);
               rd_addr  = slot_in;
            end

            if (done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status_c;
                  rsp_height_in = height_sat;
                  state_in      = ST_IDLE;
               end else begin
                  pend_status_in = status_c;
                  state_in       = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            // result waits for the output register to free up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_height_in = height_sat;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         height_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      level_ff       <= level_in;
      action_ff      <= action_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_height_ff  <= rsp_height_in;
   end

   // ram is only written while clearing or walking
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_HOLD) |-> !wr_en)
      else $error("slot ram written outside clear or walk");

   // an accepted beat always starts a walk at the root
   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WALK && level_ff == LvlW'(1)))
      else $error("accepted beat did not start a walk");

   // height stays within the tree
   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      height_ff <= LvlW'(TreeLevels))
      else $error("height beyond tree depth");

   // height never shrinks
   a_height_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> height_ff >= $past(height_ff))
      else $error("height decreased");

   // walk level stays inside the tree
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (level_ff != '0 && level_ff <= LvlW'(TreeLevels)))
      else $error("walk level out of range");

endmodule

// File: verif/tb_implicit_array_bst_top.sv
// self-checking testbench for the implicit array binary search tree top level
`timescale 1ns / 1ps

module tb_implicit_array_bst_top;
   import iabst_pkg::*;

   localparam int TREE_LEVELS = TREE_LEVELS_DEF;
   localparam int SLOT_COUNT  = 1 << TREE_LEVELS;
   // slowest legal run stays well under this limit, reset clearing pass included
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   // one expected response beat
   typedef struct packed {
      status_type          status;
      logic [HEIGHT_W-1:0] height;
   } tree_reply_type;

   logic clock;
   logic reset;

   iabst_req_if req_bus ();
   iabst_rsp_if rsp_bus ();

   implicit_array_bst_top #(
      .TreeLevels(TREE_LEVELS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // shadow copy of the tree, updated as each request beat is accepted
   logic signed [KEY_W-1:0] shadow_keys [SLOT_COUNT];
   logic                    shadow_used [SLOT_COUNT];
   int unsigned             shadow_height;

   tree_reply_type          pending_replies[$];
   logic signed [KEY_W-1:0] inserted_keys[$];

   int send_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_cycles;
   int error_count;
   int cycle_count;
   int items_sent;
   int status_seen [5];

   // free running clock, 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // cycle budget, a hang ends the run as a failure
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d replies outstanding",
                  $time, cycle_count, pending_replies.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // walk the shadow tree the way the block does; inserts modify it
   function automatic tree_reply_type predict_tree_op(input action_type act,
                                                      input logic signed [KEY_W-1:0] key);
      tree_reply_type reply;
      int unsigned    slot;
      int unsigned    level;
      slot  = 1;
      level = 1;
      if (act == ACTION_SEARCH) begin
         reply.status = STATUS_NOT_FOUND;
         // an empty slot or falling off the last level both end the search
         while (slot < SLOT_COUNT && shadow_used[slot]) begin
            if (key == shadow_keys[slot]) begin
               reply.status = STATUS_FOUND;
               break;
            end
            slot = 2 * slot + ((key > shadow_keys[slot]) ? 1 : 0);
         end
      end else begin
         // walking past the deepest level means no room, tree untouched
         reply.status = STATUS_NO_ROOM;
         while (slot < SLOT_COUNT) begin
            if (!shadow_used[slot]) begin
               shadow_keys[slot] = key;
               shadow_used[slot] = 1'b1;
               if (level > shadow_height) shadow_height = level;
               reply.status = STATUS_INSERTED;
               inserted_keys.push_back(key);
               break;
            end
            if (key == shadow_keys[slot]) begin
               reply.status = STATUS_DUPLICATE;
               break;
            end
            slot = 2 * slot + ((key > shadow_keys[slot]) ? 1 : 0);
            level++;
         end
      end
      reply.height = HEIGHT_W'((shadow_height > HEIGHT_MAX) ? HEIGHT_MAX : shadow_height);
      return reply;
   endfunction

   // drive one request beat at the falling edge, hold until accepted;
   // valid stays high into the next call so back to back beats are possible
   task automatic send_item(input action_type act, input logic signed [KEY_W-1:0] key);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  = 1'b1;
      req_bus.action = act;
      req_bus.key    = key;
      do @(posedge clock); while (!req_bus.ready);
      pending_replies.push_back(predict_tree_op(act, key));
      items_sent++;
   endtask

   // response side: random stalls, or a long counted hold when asked for
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_bus.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // compare every accepted response beat with the oldest prediction
   always @(posedge clock) begin
      tree_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_bus.status <= STATUS_NOT_FOUND) status_seen[rsp_bus.status]++;
         if (pending_replies.size() == 0) begin
            $display("%0t unexpected response beat: status %0d height %0d",
                     $time, rsp_bus.status, rsp_bus.tree_height);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.tree_height !== want.height) begin
               $display("%0t tree_height mismatch: expected %0d actual %0d",
                        $time, want.height, rsp_bus.tree_height);
               error_count++;
            end
         end
      end
   end

   // empty tree, root at key 0, duplicate on the root
   task automatic test_empty_and_root();
      send_item(ACTION_SEARCH, 0);
      send_item(ACTION_INSERT, 0);
      send_item(ACTION_SEARCH, 0);
      send_item(ACTION_INSERT, 0);
   endtask

   // most negative and most positive keys, plus a miss into an empty child
   task automatic test_key_extremes();
      send_item(ACTION_INSERT, KEY_MIN);
      send_item(ACTION_INSERT, KEY_MAX);
      send_item(ACTION_SEARCH, KEY_MIN);
      send_item(ACTION_SEARCH, KEY_MAX);
      send_item(ACTION_SEARCH, -1);
   endtask

   // a left-leaning chain under the max key down to the last level and past it,
   // so the deepest inserts find no room and the searches fall off the end
   task automatic test_depth_limit();
      for (int bit_pos = 30; bit_pos >= 32 - TREE_LEVELS - 1; bit_pos--)
         send_item(ACTION_INSERT, 32'sd1 <<< bit_pos);
      send_item(ACTION_INSERT, 32'sd1 <<< (32 - TREE_LEVELS - 2));
      send_item(ACTION_SEARCH, 32'sd1 <<< (32 - TREE_LEVELS - 2));
      send_item(ACTION_SEARCH, 32'sd1 <<< (32 - TREE_LEVELS - 1));
      send_item(ACTION_INSERT, 32'sd1 <<< (32 - TREE_LEVELS - 1));
   endtask

   // mixed inserts and searches; keys are full range, small, extreme, or
   // taken from keys already in the tree so hits and duplicates are common
   task automatic test_random_traffic(input int count);
      action_type              act;
      logic signed [KEY_W-1:0] key;
      int                      sel;
      for (int n = 0; n < count; n++) begin
         act = $urandom_range(0, 1) ? ACTION_SEARCH : ACTION_INSERT;
         sel = $urandom_range(0, 99);
         if (sel < 35 || inserted_keys.size() == 0) begin
            key = $urandom;
         end else if (sel < 60) begin
            key = int'($urandom_range(0, 40)) - 20;
         end else if (sel < 66) begin
            case ($urandom_range(0, 3))
               0:       key = KEY_MIN;
               1:       key = KEY_MAX;
               2:       key = 0;
               default: key = -1;
            endcase
         end else begin
            key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         end
         send_item(act, key);
      end
   endtask

   // response side holds off for a long counted stretch while requests keep
   // coming, so the output register and the walk behind it fill and the
   // block stops taking request beats
   task automatic test_backpressure();
      send_idle_pct   = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 400;
      test_random_traffic(24);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACTION_INSERT;
      req_bus.key     = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 16;
      rsp_idle_pct    = 56;
      rsp_hold_cycles = 0;
      error_count     = 0;
      items_sent      = 0;
      shadow_height   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (shadow_used[i]) begin
         shadow_used[i] = 1'b0;
         shadow_keys[i] = '0;
      end

      // single reset, released at a falling edge; the clearing pass that
      // follows simply holds off the first request beat
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_root();
      test_key_extremes();
      test_depth_limit();
      test_backpressure();

      // sender light, receiver heavy
      send_idle_pct = 16;
      rsp_idle_pct  = 56;
      test_random_traffic(210);
      // sender heavy, receiver light
      send_idle_pct = 56;
      rsp_idle_pct  = 16;
      test_random_traffic(210);
      // no idling on either side
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(210);

      @(negedge clock);
      req_bus.valid = 1'b0;

      // drain, then allow for a walk still in flight
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TREE_LEVELS + 4) @(posedge clock);

      $display("run covered %0d requests, tree height reached %0d", items_sent,
               shadow_height);
      $display("inserted %0d dup %0d no-room %0d found %0d not-found %0d",
               status_seen[STATUS_INSERTED], status_seen[STATUS_DUPLICATE],
               status_seen[STATUS_NO_ROOM], status_seen[STATUS_FOUND],
               status_seen[STATUS_NOT_FOUND]);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/iabst_pkg.sv
hw/rtl/iabst_if.sv
hw/rtl/iabst_slot_ram.sv
hw/rtl/implicit_array_bst_top.sv
verif/tb_implicit_array_bst_top.sv
